FILE: rtl/tdl_pkg.sv
package tdl_pkg;

    // Tree size and lifting depth
    localparam int NODES      = 1024;
    localparam int LOG_LEVELS = 10;

    localparam int NODE_W    = $clog2(NODES);
    localparam int LEVEL_W   = NODE_W;
    localparam int DIST_W    = LEVEL_W + 1;
    localparam int IDX_W     = $clog2(LOG_LEVELS);
    localparam int ANC_DEPTH = NODES * LOG_LEVELS;
    localparam int ANC_AW    = $clog2(ANC_DEPTH);

    localparam logic [IDX_W-1:0]   IDX_ONE   = IDX_W'(1);
    localparam logic [IDX_W-1:0]   IDX_TOP   = IDX_W'(LOG_LEVELS - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(NODES - 1);

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // One ancestor table entry: a node and whether it exists
    typedef struct packed {
        logic              ok;
        logic [NODE_W-1:0] node;
    } t_anc_entry;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_LVL,
        ST_LD_FIRST,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_LA,
        ST_Q_LB,
        ST_Q_ORD,
        ST_LIFT,
        ST_LIFT_TAKE,
        ST_CMP,
        ST_JU,
        ST_JV,
        ST_JT,
        ST_P0,
        ST_P1,
        ST_FIN
    } t_state;

    // Datapath register operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LD_FIRST,
        OP_LD_NEXT,
        OP_Q_LU,
        OP_Q_ORDER,
        OP_LIFT_TAKE,
        OP_CMP_EQ,
        OP_NOT_FOUND,
        OP_J_EU,
        OP_J_STEP,
        OP_P1,
        OP_FIN
    } t_dp_op;

    // Lifting index updates
    typedef enum logic [2:0] {
        IX_HOLD,
        IX_ONE,
        IX_INC,
        IX_DEC,
        IX_TOP
    } t_idx_op;

    // Ancestor table read address sources
    typedef enum logic [1:0] {
        AS_PREV,
        AS_U,
        AS_V,
        AS_U0
    } t_anc_src;

    // Level memory read address sources
    typedef enum logic [1:0] {
        LS_A,
        LS_B,
        LS_U,
        LS_ANC
    } t_lvl_src;

    typedef struct packed {
        t_dp_op   op;
        t_idx_op  idx_op;
        logic     anc_rd_en;
        t_anc_src anc_src;
        logic     lvl_rd_en;
        t_lvl_src lvl_src;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_zero;
        logic idx_last;
        logic diff_bit;
        logic rd_ok;
        logic cur_ok;
        logic u_eq_v;
        logic out_free;
    } t_dp_status;

    // Flat address of entry idx in the row of node
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [IDX_W-1:0]  idx);
        return ANC_AW'(node) * ANC_AW'(LOG_LEVELS) + ANC_AW'(idx);
    endfunction

endpackage

FILE: rtl/tdl_ctrl.sv
module tdl_ctrl
    import tdl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_kind,
    input  t_dp_status i_status,
    output logic       o_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_kind == KIND_QUERY) ? ST_Q_LA : ST_LD_LVL;
                end
            end
            ST_LD_LVL:   n_state = ST_LD_FIRST;
            ST_LD_FIRST: n_state = (LOG_LEVELS > 1) ? ST_LD_RD : ST_IDLE;
            ST_LD_RD:    n_state = ST_LD_WR;
            ST_LD_WR:    n_state = i_status.idx_last ? ST_IDLE : ST_LD_RD;
            ST_Q_LA:     n_state = ST_Q_LB;
            ST_Q_LB:     n_state = ST_Q_ORD;
            ST_Q_ORD:    n_state = ST_LIFT;
            ST_LIFT: begin
                if (i_status.diff_bit) begin
                    n_state = ST_LIFT_TAKE;
                end else if (i_status.idx_zero) begin
                    n_state = ST_CMP;
                end
            end
            ST_LIFT_TAKE: begin
                n_state = (!i_status.rd_ok || i_status.idx_zero) ? ST_CMP : ST_LIFT;
            end
            ST_CMP: begin
                if (!i_status.cur_ok || i_status.u_eq_v) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_JU;
                end
            end
            ST_JU: n_state = ST_JV;
            ST_JV: n_state = ST_JT;
            ST_JT: n_state = i_status.idx_zero ? ST_P0 : ST_JU;
            ST_P0: n_state = ST_P1;
            ST_P1: n_state = ST_FIN;
            ST_FIN: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = OP_NONE;
        o_cmd.idx_op    = IX_HOLD;
        o_cmd.anc_src   = AS_U;
        o_cmd.lvl_src   = LS_A;
        o_stall         = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_CAPTURE;
                end
            end
            ST_LD_LVL: begin
                o_cmd.lvl_rd_en = 1'b1;
                o_cmd.lvl_src   = LS_B;
            end
            ST_LD_FIRST: begin
                o_cmd.op     = OP_LD_FIRST;
                o_cmd.idx_op = IX_ONE;
            end
            ST_LD_RD: begin
                o_cmd.anc_rd_en = 1'b1;
                o_cmd.anc_src   = AS_PREV;
            end
            ST_LD_WR: begin
                o_cmd.op     = OP_LD_NEXT;
                o_cmd.idx_op = IX_INC;
            end
            ST_Q_LA: begin
                o_cmd.lvl_rd_en = 1'b1;
                o_cmd.lvl_src   = LS_A;
            end
            ST_Q_LB: begin
                o_cmd.op        = OP_Q_LU;
                o_cmd.lvl_rd_en = 1'b1;
                o_cmd.lvl_src   = LS_B;
            end
            ST_Q_ORD: begin
                o_cmd.op     = OP_Q_ORDER;
                o_cmd.idx_op = IX_TOP;
            end
            ST_LIFT: begin
                if (i_status.diff_bit) begin
                    o_cmd.anc_rd_en = 1'b1;
                    o_cmd.anc_src   = AS_U;
                end else if (!i_status.idx_zero) begin
                    o_cmd.idx_op = IX_DEC;
                end
            end
            ST_LIFT_TAKE: begin
                o_cmd.op = OP_LIFT_TAKE;
                if (i_status.rd_ok && !i_status.idx_zero) begin
                    o_cmd.idx_op = IX_DEC;
                end
            end
            ST_CMP: begin
                if (!i_status.cur_ok) begin
                    o_cmd.op = OP_NOT_FOUND;
                end else if (i_status.u_eq_v) begin
                    o_cmd.op        = OP_CMP_EQ;
                    o_cmd.lvl_rd_en = 1'b1;
                    o_cmd.lvl_src   = LS_U;
                end else begin
                    o_cmd.idx_op = IX_TOP;
                end
            end
            ST_JU: begin
                o_cmd.anc_rd_en = 1'b1;
                o_cmd.anc_src   = AS_U;
            end
            ST_JV: begin
                o_cmd.op        = OP_J_EU;
                o_cmd.anc_rd_en = 1'b1;
                o_cmd.anc_src   = AS_V;
            end
            ST_JT: begin
                o_cmd.op = OP_J_STEP;
                if (!i_status.idx_zero) begin
                    o_cmd.idx_op = IX_DEC;
                end
            end
            ST_P0: begin
                o_cmd.anc_rd_en = 1'b1;
                o_cmd.anc_src   = AS_U0;
            end
            ST_P1: begin
                o_cmd.op        = OP_P1;
                o_cmd.lvl_rd_en = 1'b1;
                o_cmd.lvl_src   = LS_ANC;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_FIN;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/tdl_datapath.sv
module tdl_datapath
    import tdl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [NODE_W-1:0]  i_node_a,
    input  logic [NODE_W-1:0]  i_node_b,
    input  logic               i_has_parent,
    input  logic               i_stall,
    output t_dp_status         o_status,
    output logic               o_valid,
    output logic [DIST_W-1:0]  o_distance,
    output logic [NODE_W-1:0]  o_common_ancestor
);

    // Ancestor table and level store, no reset
    t_anc_entry         anc_mem [ANC_DEPTH];
    logic [LEVEL_W-1:0] lvl_mem [NODES];

    // Captured item
    logic [NODE_W-1:0]  r_a;
    logic [NODE_W-1:0]  r_b;
    logic               r_has_parent;

    // Working registers
    t_anc_entry         r_anc_q;
    logic [LEVEL_W-1:0] r_lvl_q;
    t_anc_entry         r_prev;
    t_anc_entry         r_eu;
    logic [NODE_W-1:0]  r_u;
    logic [NODE_W-1:0]  r_v;
    logic               r_cur_ok;
    logic [LEVEL_W-1:0] r_lu;
    logic [LEVEL_W-1:0] r_lv;
    logic [LEVEL_W-1:0] r_diff;
    logic [IDX_W-1:0]   r_idx;
    logic [NODE_W-1:0]  r_lca;
    logic               r_found;

    // Output register
    logic               r_out_valid;
    logic [DIST_W-1:0]  r_distance;
    logic [NODE_W-1:0]  r_common_ancestor;

    logic [ANC_AW-1:0]  anc_rd_addr;
    logic [ANC_AW-1:0]  anc_wr_addr;
    t_anc_entry         anc_wr_data;
    logic               anc_we;
    logic [NODE_W-1:0]  lvl_rd_addr;
    logic [LEVEL_W-1:0] lvl_wr_data;
    logic               lvl_we;
    logic [LEVEL_W-1:0] level_inc;
    logic [DIST_W-1:0]  level_sum;
    logic [DIST_W-1:0]  level_twice;
    logic [LEVEL_W-1:0] lca_level;
    logic               out_free;

    assign out_free = !r_out_valid || !i_stall;

    // Parent level plus one, saturating
    assign level_inc = (r_lvl_q >= LEVEL_MAX) ? LEVEL_MAX : r_lvl_q + 1'b1;

    // Read address selection
    always_comb begin
        unique case (i_cmd.anc_src)
            AS_PREV: anc_rd_addr = anc_addr(r_prev.node, r_idx - IDX_ONE);
            AS_U:    anc_rd_addr = anc_addr(r_u, r_idx);
            AS_V:    anc_rd_addr = anc_addr(r_v, r_idx);
            AS_U0:   anc_rd_addr = anc_addr(r_u, '0);
            default: anc_rd_addr = anc_addr(r_u, r_idx);
        endcase
        unique case (i_cmd.lvl_src)
            LS_A:    lvl_rd_addr = r_a;
            LS_B:    lvl_rd_addr = r_b;
            LS_U:    lvl_rd_addr = r_u;
            LS_ANC:  lvl_rd_addr = r_anc_q.node;
            default: lvl_rd_addr = r_a;
        endcase
    end

    // Row fill writes during a load
    always_comb begin
        anc_we      = 1'b0;
        anc_wr_addr = anc_addr(r_a, r_idx);
        anc_wr_data = '0;
        lvl_we      = 1'b0;
        lvl_wr_data = r_has_parent ? level_inc : '0;
        if (i_cmd.op == OP_LD_FIRST) begin
            anc_we      = 1'b1;
            lvl_we      = 1'b1;
            anc_wr_addr = anc_addr(r_a, '0);
            anc_wr_data = r_has_parent ? t_anc_entry'{ok: 1'b1, node: r_b} : '0;
        end else if (i_cmd.op == OP_LD_NEXT) begin
            anc_we      = 1'b1;
            anc_wr_data = r_prev.ok ? r_anc_q : '0;
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            anc_mem[anc_wr_addr] <= anc_wr_data;
        end
        if (i_cmd.anc_rd_en) begin
            r_anc_q <= anc_mem[anc_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            lvl_mem[r_a] <= lvl_wr_data;
        end
        if (i_cmd.lvl_rd_en) begin
            r_lvl_q <= lvl_mem[lvl_rd_addr];
        end
    end

    // Distance: lu + lv - 2 * level(lca), floored at zero
    assign lca_level   = r_found ? r_lvl_q : '0;
    assign level_sum   = DIST_W'(r_lu) + DIST_W'(r_lv);
    assign level_twice = {lca_level, 1'b0};

    // Working register updates
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_a          <= i_node_a;
                r_b          <= i_node_b;
                r_has_parent <= i_has_parent;
            end
            OP_LD_FIRST: begin
                r_prev <= anc_wr_data;
            end
            OP_LD_NEXT: begin
                r_prev <= anc_wr_data;
            end
            OP_Q_LU: begin
                r_lu <= r_lvl_q;
            end
            OP_Q_ORDER: begin
                r_lv     <= r_lvl_q;
                r_cur_ok <= 1'b1;
                if (r_lu < r_lvl_q) begin
                    r_u    <= r_b;
                    r_v    <= r_a;
                    r_diff <= r_lvl_q - r_lu;
                end else begin
                    r_u    <= r_a;
                    r_v    <= r_b;
                    r_diff <= r_lu - r_lvl_q;
                end
            end
            OP_LIFT_TAKE: begin
                r_u      <= r_anc_q.node;
                r_cur_ok <= r_anc_q.ok;
            end
            OP_CMP_EQ: begin
                r_lca   <= r_u;
                r_found <= 1'b1;
            end
            OP_NOT_FOUND: begin
                r_lca   <= '0;
                r_found <= 1'b0;
            end
            OP_J_EU: begin
                r_eu <= r_anc_q;
            end
            OP_J_STEP: begin
                // both exist and differ: lift both
                if (r_eu.ok && r_anc_q.ok && (r_eu.node != r_anc_q.node)) begin
                    r_u <= r_eu.node;
                    r_v <= r_anc_q.node;
                end
            end
            OP_P1: begin
                r_found <= r_anc_q.ok;
                r_lca   <= r_anc_q.ok ? r_anc_q.node : '0;
            end
            OP_FIN: begin
                r_distance        <= (level_sum < level_twice) ? '0
                                                               : level_sum - level_twice;
                r_common_ancestor <= r_lca;
            end
            default: begin
            end
        endcase
    end

    // Lifting index
    always_ff @(posedge i_clk) begin
        case (i_cmd.idx_op)
            IX_ONE:  r_idx <= IDX_ONE;
            IX_INC:  r_idx <= r_idx + IDX_ONE;
            IX_DEC:  r_idx <= r_idx - IDX_ONE;
            IX_TOP:  r_idx <= IDX_TOP;
            default: r_idx <= r_idx;
        endcase
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FIN) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Status to the controller
    always_comb begin
        o_status.idx_zero = (r_idx == '0);
        o_status.idx_last = (r_idx == IDX_TOP);
        o_status.diff_bit = r_diff[r_idx];
        o_status.rd_ok    = r_anc_q.ok;
        o_status.cur_ok   = r_cur_ok;
        o_status.u_eq_v   = (r_u == r_v);
        o_status.out_free = out_free;
    end

    assign o_valid           = r_out_valid;
    assign o_distance        = r_distance;
    assign o_common_ancestor = r_common_ancestor;

endmodule

FILE: rtl/tree_distance_lca_lifting_unit.sv
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_kind, i_node_a, i_node_b, i_has_parent
// result   out        o_valid / i_stall   o_distance, o_common_ancestor
//
// One item at a time; a load fills the row of its node in the ancestor table one entry
// after another, each entry first read from the table and then written (read, then write).
// A query lifts the deeper node by the level gap and, when the nodes differ after
// levelling, lifts both while their ancestors differ; it ends early when they meet.
// Synchronous active-low reset clears the controller and the result valid only;
// the tables hold whatever they held and each entry is defined once loaded.
// A finished result waits in the output register; a stalled result holds the
// next query at its last step, loads run on regardless.
module tree_distance_lca_lifting_unit
    import tdl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_kind,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_has_parent,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DIST_W-1:0] o_distance,
    output logic [NODE_W-1:0] o_common_ancestor
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tdl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    tdl_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_node_a          (i_node_a),
        .i_node_b          (i_node_b),
        .i_has_parent      (i_has_parent),
        .i_stall           (i_stall),
        .o_status          (status),
        .o_valid           (o_valid),
        .o_distance        (o_distance),
        .o_common_ancestor (o_common_ancestor)
    );

    // An accepted item is captured and the block goes busy
    a_accept_capture : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> (cmd.op == OP_CAPTURE))
        else $error("accepted item not captured");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting an item");

    // A result is only written when the output register is free
    a_fin_out_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_FIN) |-> (!o_valid || !i_stall))
        else $error("result overwrote a waiting result");

    a_fin_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_FIN) |=> o_valid)
        else $error("finished query gave no result");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tdl_pkg::*;

    // Run sizing; the cycle limit is several times the slowest legal run
    // (every item a worst-case query behind the longest sender gap and receiver stall).
    localparam int ITEM_TARGET = 1900;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    // One expected query result
    typedef struct packed {
        logic [DIST_W-1:0] path_len;
        logic [NODE_W-1:0] anc;
    } t_path_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_kind;
    logic [NODE_W-1:0] i_node_a;
    logic [NODE_W-1:0] i_node_b;
    logic              i_has_parent;
    logic              o_valid;
    logic              i_stall;
    logic [DIST_W-1:0] o_distance;
    logic [NODE_W-1:0] o_common_ancestor;

    // Shadow copy of the lifting table and node levels
    t_anc_entry         lift_rows [ANC_DEPTH];
    logic [LEVEL_W-1:0] node_depth [NODES];
    bit                 node_known [NODES];
    int                 known_nodes [$];
    bit                 in_tree [NODES];

    t_path_result pending_paths [$];

    int  items_sent;
    int  loads_sent;
    int  queries_sent;
    int  results_seen;
    int  fault_count;
    int  cycle_count;
    bit  tx_idle_on;
    bit  rx_idle_on;
    int  hold_req;

    tree_distance_lca_lifting_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_node_a          (i_node_a),
        .i_node_b          (i_node_b),
        .i_has_parent      (i_has_parent),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_distance        (o_distance),
        .o_common_ancestor (o_common_ancestor)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Fill the row of a loaded node, low entries first
    function automatic void record_node(input logic [NODE_W-1:0] a,
                                        input logic [NODE_W-1:0] b,
                                        input logic hp);
        int                 row;
        int                 i;
        logic [LEVEL_W-1:0] up;
        t_anc_entry         prev;
        row = int'(a) * LOG_LEVELS;
        if (hp) begin
            up = node_depth[b];
            node_depth[a] = (up >= LEVEL_MAX) ? LEVEL_MAX : up + 1'b1;
            lift_rows[row] = '{ok: 1'b1, node: b};
        end else begin
            node_depth[a] = '0;
            lift_rows[row] = '0;
        end
        for (i = 1; i < LOG_LEVELS; i++) begin
            prev = lift_rows[row + i - 1];
            if (prev.ok) begin
                lift_rows[row + i] = lift_rows[int'(prev.node) * LOG_LEVELS + i - 1];
            end else begin
                lift_rows[row + i] = '0;
            end
        end
        if (!node_known[a]) begin
            node_known[a] = 1'b1;
            known_nodes = {known_nodes, int'(a)};
        end
    endfunction

    // Lowest common ancestor and path length between two nodes
    function automatic t_path_result lca_distance(input logic [NODE_W-1:0] a,
                                                  input logic [NODE_W-1:0] b);
        logic [NODE_W-1:0]  u;
        logic [NODE_W-1:0]  v;
        logic [NODE_W-1:0]  t;
        logic [NODE_W-1:0]  lca;
        logic [LEVEL_W-1:0] lvl_a;
        logic [LEVEL_W-1:0] lvl_b;
        logic [LEVEL_W-1:0] gap;
        logic [LEVEL_W-1:0] lvl_lca;
        t_anc_entry         cur;
        t_anc_entry         eu;
        t_anc_entry         ev;
        logic               found;
        logic               same;
        int                 d;
        int                 i;
        t_path_result       res;
        u = a;
        v = b;
        lvl_a = node_depth[a];
        lvl_b = node_depth[b];
        lca = '0;
        lvl_lca = '0;
        found = 1'b0;
        if (node_depth[u] < node_depth[v]) begin
            t = u;
            u = v;
            v = t;
        end
        // bring the deeper node up; stop once past the root
        gap = node_depth[u] - node_depth[v];
        cur = '{ok: 1'b1, node: u};
        for (i = LOG_LEVELS - 1; i >= 0 && cur.ok; i--) begin
            if (((gap >> i) & 1) != 0) begin
                cur = lift_rows[int'(cur.node) * LOG_LEVELS + i];
            end
        end
        if (cur.ok) begin
            u = cur.node;
            if (u == v) begin
                lca = u;
                found = 1'b1;
            end else begin
                // lift both while their ancestors differ
                for (i = LOG_LEVELS - 1; i >= 0; i--) begin
                    eu = lift_rows[int'(u) * LOG_LEVELS + i];
                    ev = lift_rows[int'(v) * LOG_LEVELS + i];
                    same = (eu.ok == ev.ok) && (!eu.ok || eu.node == ev.node);
                    if (!same && eu.ok && ev.ok) begin
                        u = eu.node;
                        v = ev.node;
                    end
                end
                cur = lift_rows[int'(u) * LOG_LEVELS];
                if (cur.ok) begin
                    lca = cur.node;
                    found = 1'b1;
                end
            end
        end
        if (found) begin
            lvl_lca = node_depth[lca];
        end else begin
            lca = '0;
        end
        d = int'(lvl_a) + int'(lvl_b) - 2 * int'(lvl_lca);
        if (d < 0) d = 0;
        if (d > DIST_MAX) d = DIST_MAX;
        res.path_len = DIST_W'(d);
        res.anc = lca;
        return res;
    endfunction

    // Mostly short idle stretches, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (!tx_idle_on) return 0;
        if ($urandom_range(0, 99) < 55) return 0;
        return gap_len();
    endfunction

    function automatic int pick_known();
        return known_nodes[$urandom_range(0, known_nodes.size() - 1)];
    endfunction

    function automatic int fresh_node();
        int n;
        do n = $urandom_range(0, NODES - 1); while (in_tree[n]);
        return n;
    endfunction

    // Offer one item, wait for acceptance, update the shadow state, then idle a while.
    // Entered and left just after a falling edge.
    task automatic offer_item(input logic kind, input int a, input int b, input logic hp);
        int gap;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_node_a <= NODE_W'(a);
        i_node_b <= NODE_W'(b);
        i_has_parent <= hp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (kind == KIND_QUERY) begin
            pending_paths = {pending_paths, lca_distance(NODE_W'(a), NODE_W'(b))};
            queries_sent++;
        end else begin
            record_node(NODE_W'(a), NODE_W'(b), hp);
            loads_sent++;
        end
        items_sent++;
        @(negedge i_clk);
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Small hand-built forest: extremes, self parent, reloads, cross-tree and stale lifts
    task automatic test_directed();
        offer_item(KIND_LOAD, 1023, 1023, 1'b0);
        offer_item(KIND_LOAD, 0, 1023, 1'b1);
        offer_item(KIND_LOAD, 512, 0, 1'b1);
        offer_item(KIND_LOAD, 1, 0, 1'b1);
        offer_item(KIND_LOAD, 700, 512, 1'b1);
        offer_item(KIND_QUERY, 700, 1, 1'b0);
        offer_item(KIND_QUERY, 700, 700, 1'b1);
        offer_item(KIND_QUERY, 1023, 700, 1'b0);
        offer_item(KIND_QUERY, 1, 512, 1'b1);
        offer_item(KIND_QUERY, 1023, 1023, 1'b0);
        // second tree, then queries across trees
        offer_item(KIND_LOAD, 5, 0, 1'b0);
        offer_item(KIND_QUERY, 5, 700, 1'b0);
        // node made its own parent: ancestor deeper than the pair, distance clamps at zero
        offer_item(KIND_LOAD, 5, 5, 1'b1);
        offer_item(KIND_QUERY, 5, 1023, 1'b1);
        // cut the chain under 700 so a lift runs off the root
        offer_item(KIND_LOAD, 0, 1023, 1'b0);
        offer_item(KIND_QUERY, 700, 1023, 1'b0);
        offer_item(KIND_QUERY, 700, 1, 1'b1);
        offer_item(KIND_QUERY, 0, 0, 1'b0);
    endtask

    // Chain through every node, deepest queries, then level saturation
    task automatic test_deep_chain();
        int k;
        offer_item(KIND_LOAD, 0, $urandom_range(0, NODES - 1), 1'b0);
        for (k = 1; k < NODES; k++) begin
            offer_item(KIND_LOAD, k, k - 1, 1'b1);
        end
        offer_item(KIND_QUERY, 1023, 0, 1'b0);
        offer_item(KIND_QUERY, 0, 1023, 1'b1);
        offer_item(KIND_QUERY, 1023, 1022, 1'b0);
        offer_item(KIND_QUERY, 1023, 512, 1'b0);
        offer_item(KIND_QUERY, 1, 1022, 1'b1);
        offer_item(KIND_QUERY, 700, 300, 1'b0);
        repeat (20) begin
            offer_item(KIND_QUERY, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                       $urandom_range(0, 1));
        end
        // deepest node under itself: level stays at the top
        offer_item(KIND_LOAD, 1023, 1023, 1'b1);
        offer_item(KIND_QUERY, 1023, 3, 1'b0);
        // close the chain into a loop, again at the top level
        offer_item(KIND_LOAD, 0, 1023, 1'b1);
        offer_item(KIND_QUERY, 0, 1023, 1'b1);
        offer_item(KIND_QUERY, 0, 500, 1'b0);
        offer_item(KIND_QUERY, 900, 0, 1'b0);
    endtask

    // Receiver holds off while queries keep coming, so the block backs up
    task automatic test_output_backlog();
        tx_idle_on = 1'b0;
        hold_req = HOLD_CYCLES;
        repeat (12) begin
            offer_item(KIND_QUERY, pick_known(), pick_known(), $urandom_range(0, 1));
        end
        tx_idle_on = 1'b1;
    endtask

    // One random tree grown parent before child, queried as it grows, with some noise
    task automatic grow_forest();
        int size_goal;
        int step;
        int r;
        int a;
        int b;
        int back;
        int members [$];
        size_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(4, 40);
        tx_idle_on = ($urandom_range(0, 4) != 0);
        rx_idle_on = ($urandom_range(0, 4) != 0);
        a = fresh_node();
        in_tree[a] = 1'b1;
        members = {members, a};
        offer_item(KIND_LOAD, a, $urandom_range(0, NODES - 1), 1'b0);
        for (step = 1; step < 2 * size_goal; step++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                // reload anywhere: leaves stale rows behind
                offer_item(KIND_LOAD, pick_known(), pick_known(), $urandom_range(0, 1));
            end else if (r < 12) begin
                offer_item(KIND_QUERY, pick_known(), pick_known(), $urandom_range(0, 1));
            end else if (members.size() < size_goal && (r < 60 || members.size() < 3)) begin
                a = fresh_node();
                if ($urandom_range(0, 1) == 1) begin
                    back = $urandom_range(0, 2);
                    if (back >= members.size()) back = members.size() - 1;
                    b = members[members.size() - 1 - back];
                end else begin
                    b = members[$urandom_range(0, members.size() - 1)];
                end
                in_tree[a] = 1'b1;
                members = {members, a};
                offer_item(KIND_LOAD, a, b, 1'b1);
            end else begin
                offer_item(KIND_QUERY, members[$urandom_range(0, members.size() - 1)],
                           members[$urandom_range(0, members.size() - 1)],
                           $urandom_range(0, 1));
            end
        end
        foreach (members[i]) in_tree[members[i]] = 1'b0;
    endtask

    task automatic test_random_forests();
        while (items_sent < ITEM_TARGET) grow_forest();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver stall: random runs, or a long hold when one is requested
    initial begin
        int hold_left;
        int run_left;
        bit run_stall;
        hold_left = 0;
        run_left = 0;
        run_stall = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!rx_idle_on) begin
                i_stall <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                run_stall = ($urandom_range(0, 99) < 30);
                run_left = run_stall ? gap_len() : $urandom_range(1, 8);
                i_stall <= run_stall;
            end
        end
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge i_clk) begin
        t_path_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_paths.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected result: distance %0d ancestor %0d",
                             o_distance, o_common_ancestor);
                end
            end else begin
                want = pending_paths.pop_front();
                results_seen++;
                if (o_distance !== want.path_len || o_common_ancestor !== want.anc) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("result %0d: expected distance %0d ancestor %0d, got %0d %0d",
                                 results_seen, want.path_len, want.anc,
                                 o_distance, o_common_ancestor);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tree_distance_lca_lifting_unit: mismatch");
        $finish;
    end

    initial begin
        items_sent = 0;
        loads_sent = 0;
        queries_sent = 0;
        results_seen = 0;
        fault_count = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = KIND_LOAD;
        i_node_a = '0;
        i_node_b = '0;
        i_has_parent = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_deep_chain();
        test_output_backlog();
        test_random_forests();

        // let the last item finish, then allow for a trailing load
        i_valid <= 1'b0;
        while (pending_paths.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items: %0d loads, %0d queries, %0d results checked, %0d faults",
                 items_sent, loads_sent, queries_sent, results_seen, fault_count);
        $display("covered a full-depth chain with level saturation, stale and cross-tree lifts");
        if (fault_count == 0 && pending_paths.size() == 0) begin
            $display("tree_distance_lca_lifting_unit: match");
        end else begin
            $display("tree_distance_lca_lifting_unit: mismatch");
        end
        $finish;
    end

endmodule
